>>> hw/rtl/vta_pkg.sv
// Package for the vibration tamper alarm: item, config and result types,
// command, mode and action codes, and register reset values.
// Depends on nothing; used by vta_cfg_regs, vta_core and the top level.
package vta_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CountW  = 4;
  localparam int unsigned RegIdxW = 3;

  localparam logic [CountW-1:0] WindowMax = 4'd15;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_ALARM    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_WARN_CHIRP  = 3'd1,
    ACT_SIREN_ALERT = 3'd2,
    ACT_SIREN_TMO   = 3'd3,
    ACT_ARM_CHIRP   = 3'd4,
    ACT_DISARM      = 3'd5,
    ACT_RESET_STOP  = 3'd6
  } action_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_WINDOW    = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_HOLD      = 3'd3,
    REG_PREWARN   = 3'd4,
    REG_QUIET     = 3'd5
  } reg_idx_t;

  localparam logic [MsW-1:0]    DebounceRst  = 16'd100;
  localparam logic [MsW-1:0]    WindowRst    = 16'd3000;
  localparam logic [CountW-1:0] ThresholdRst = 4'd4;
  localparam logic [MsW-1:0]    HoldRst      = 16'd20000;
  localparam logic [MsW-1:0]    PrewarnRst   = 16'd2500;
  localparam logic [MsW-1:0]    QuietRst     = 16'd3000;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             sensor_level;
    logic [TimeW-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        action;
    logic              vibration_active;
    logic [CountW-1:0] window_pulses;
    logic [TimeW-1:0]  total_pulses;
  } out_item_t;

  typedef struct packed {
    logic [RegIdxW-1:0] reg_index;
    logic [MsW-1:0]     wr_data;
  } cfg_wr_t;

  typedef struct packed {
    logic [MsW-1:0]    debounce_ms;
    logic [MsW-1:0]    window_ms;
    logic [CountW-1:0] shock_threshold;
    logic [MsW-1:0]    hold_ms;
    logic [MsW-1:0]    prewarn_gap_ms;
    logic [MsW-1:0]    quiet_ms;
  } cfg_t;

endpackage

>>> hw/rtl/vta_stream_if.sv
// Valid/ready channel interface shared by the item, result and config ports.
// Payload type is a parameter; typical payloads come from vta_pkg.
interface vta_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/vta_cfg_regs.sv
// Configuration register file for the tamper alarm, written over a
// valid/ready channel. Depends on vta_pkg and vta_stream_if.
module vta_cfg_regs (
  input  logic         clk,
  input  logic         rst_n,
  vta_stream_if.sink   cfg_ch,
  output vta_pkg::cfg_t cfg
);

  vta_pkg::cfg_t cfg_r;
  vta_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (vta_pkg::reg_idx_t'(cfg_ch.data.reg_index))
        vta_pkg::REG_DEBOUNCE:  cfg_nxt.debounce_ms     = cfg_ch.data.wr_data;
        vta_pkg::REG_WINDOW:    cfg_nxt.window_ms       = cfg_ch.data.wr_data;
        vta_pkg::REG_THRESHOLD: cfg_nxt.shock_threshold =
                                  cfg_ch.data.wr_data[vta_pkg::CountW-1:0];
        vta_pkg::REG_HOLD:      cfg_nxt.hold_ms         = cfg_ch.data.wr_data;
        vta_pkg::REG_PREWARN:   cfg_nxt.prewarn_gap_ms  = cfg_ch.data.wr_data;
        vta_pkg::REG_QUIET:     cfg_nxt.quiet_ms        = cfg_ch.data.wr_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= vta_pkg::DebounceRst;
      cfg_r.window_ms       <= vta_pkg::WindowRst;
      cfg_r.shock_threshold <= vta_pkg::ThresholdRst;
      cfg_r.hold_ms         <= vta_pkg::HoldRst;
      cfg_r.prewarn_gap_ms  <= vta_pkg::PrewarnRst;
      cfg_r.quiet_ms        <= vta_pkg::QuietRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hw/rtl/vta_core.sv
// Alarm state and single-pass update logic: one item in, state after the
// item out. Depends on vta_pkg.
module vta_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  vta_pkg::in_item_t   item,
  input  vta_pkg::cfg_t       cfg,
  output vta_pkg::out_item_t  result
);

  localparam int unsigned TW = vta_pkg::TimeW;
  localparam int unsigned CW = vta_pkg::CountW;

  vta_pkg::mode_t mode_r, mode_nxt;
  logic           prev_level_r, prev_level_nxt;
  logic [CW-1:0]  win_cnt_r, win_cnt_nxt;
  logic [TW-1:0]  win_start_r, win_start_nxt;
  logic [TW-1:0]  last_pulse_r, last_pulse_nxt;
  logic [TW-1:0]  last_warn_r, last_warn_nxt;
  logic [TW-1:0]  alarm_start_r, alarm_start_nxt;
  logic [TW-1:0]  total_r, total_nxt;
  logic           vib_r, vib_nxt;

  logic [TW-1:0]   now;
  logic            win_expired;
  logic            counted;
  logic [CW-1:0]   cnt_base;
  logic [CW-1:0]   cnt_inc;
  vta_pkg::mode_t  mode_mid;
  logic [TW-1:0]   alarm_mid;
  vta_pkg::action_t action;

  assign now = item.time_ms;

  always_comb begin
    mode_nxt        = mode_r;
    prev_level_nxt  = prev_level_r;
    win_cnt_nxt     = win_cnt_r;
    win_start_nxt   = win_start_r;
    last_pulse_nxt  = last_pulse_r;
    last_warn_nxt   = last_warn_r;
    alarm_start_nxt = alarm_start_r;
    total_nxt       = total_r;
    vib_nxt         = vib_r;
    action          = vta_pkg::ACT_NONE;

    win_expired = (win_cnt_r != '0) &&
                  ((now - win_start_r) > {{(TW-vta_pkg::MsW){1'b0}}, cfg.window_ms});
    cnt_base    = win_expired ? '0 : win_cnt_r;
    cnt_inc     = (cnt_base == vta_pkg::WindowMax) ? cnt_base : cnt_base + 1'b1;
    counted     = item.sensor_level && !prev_level_r &&
                  ((now - last_pulse_r) > {{(TW-vta_pkg::MsW){1'b0}}, cfg.debounce_ms});
    mode_mid    = mode_r;
    alarm_mid   = alarm_start_r;

    case (vta_pkg::cmd_t'(item.cmd))
      vta_pkg::CMD_SAMPLE: begin
        win_cnt_nxt    = cnt_base;
        prev_level_nxt = item.sensor_level;
        if (counted) begin
          last_pulse_nxt = now;
          total_nxt      = total_r + 1'b1;
          vib_nxt        = 1'b1;
          win_cnt_nxt    = cnt_inc;
          if (cnt_base == '0) begin
            win_start_nxt = now;
          end
          if (mode_r == vta_pkg::MODE_ARMED) begin
            if (cnt_inc < cfg.shock_threshold) begin
              if ((now - last_warn_r) >
                  {{(TW-vta_pkg::MsW){1'b0}}, cfg.prewarn_gap_ms}) begin
                last_warn_nxt = now;
                action        = vta_pkg::ACT_WARN_CHIRP;
              end
            end else begin
              win_cnt_nxt = '0;
              mode_mid    = vta_pkg::MODE_ALARM;
              alarm_mid   = now;
              action      = vta_pkg::ACT_SIREN_ALERT;
            end
          end
        end else if (!item.sensor_level) begin
          if ((now - last_pulse_r) > {{(TW-vta_pkg::MsW){1'b0}}, cfg.quiet_ms}) begin
            vib_nxt = 1'b0;
          end
        end
        alarm_start_nxt = alarm_mid;
        mode_nxt        = mode_mid;
        // Alarm timeout is checked after edge handling, on samples only.
        if (mode_mid == vta_pkg::MODE_ALARM &&
            (now - alarm_mid) > {{(TW-vta_pkg::MsW){1'b0}}, cfg.hold_ms}) begin
          mode_nxt = vta_pkg::MODE_ARMED;
          action   = vta_pkg::ACT_SIREN_TMO;
        end
      end
      vta_pkg::CMD_ARM: begin
        mode_nxt = vta_pkg::MODE_ARMED;
        action   = vta_pkg::ACT_ARM_CHIRP;
      end
      vta_pkg::CMD_DISARM: begin
        mode_nxt = vta_pkg::MODE_DISARMED;
        action   = vta_pkg::ACT_DISARM;
      end
      vta_pkg::CMD_RESET: begin
        if (mode_r == vta_pkg::MODE_ALARM) begin
          mode_nxt = vta_pkg::MODE_ARMED;
          action   = vta_pkg::ACT_RESET_STOP;
        end
      end
      default: ;
    endcase
  end

  assign result.mode             = mode_nxt;
  assign result.action           = action;
  assign result.vibration_active = vib_nxt;
  assign result.window_pulses    = win_cnt_nxt;
  assign result.total_pulses     = total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= vta_pkg::MODE_ARMED;
      prev_level_r  <= 1'b0;
      win_cnt_r     <= '0;
      win_start_r   <= '0;
      last_pulse_r  <= '0;
      last_warn_r   <= '0;
      alarm_start_r <= '0;
      total_r       <= '0;
      vib_r         <= 1'b0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      prev_level_r  <= prev_level_nxt;
      win_cnt_r     <= win_cnt_nxt;
      win_start_r   <= win_start_nxt;
      last_pulse_r  <= last_pulse_nxt;
      last_warn_r   <= last_warn_nxt;
      alarm_start_r <= alarm_start_nxt;
      total_r       <= total_nxt;
      vib_r         <= vib_nxt;
    end
  end

endmodule

>>> hw/rtl/vibration_tamper_alarm.sv
// Top level of the vibration tamper alarm: input register, update logic and
// result register. Depends on vta_pkg, vta_stream_if, vta_cfg_regs, vta_core.
//
// The block takes one item per clock while in_ch.ready is high: a
// timestamped sensor sample or an arm, disarm or reset-alarm command, and
// returns exactly one result item for each, showing mode, action, vibration
// flag, window pulse count and total pulse count after that item. An item
// passes an input register and is processed by the combinational update
// logic, which writes the alarm state and the result register at the same
// edge; throughput is one item per cycle while the result side is not
// stalled. The result register decouples the sides: a new item is taken
// while a result waits, and only a full pipe with the result side stalled
// holds back in_ch.ready. Configuration writes on cfg_ch are always
// accepted; write them only while no item is in flight.
// Register indexes 0..5 are debounce_ms, window_ms, shock_threshold,
// hold_ms, prewarn_gap_ms and quiet_ms; other indexes are ignored.
module vibration_tamper_alarm (
  input  logic         clk,
  input  logic         rst_n,
  vta_stream_if.sink   in_ch,
  vta_stream_if.source out_ch,
  vta_stream_if.sink   cfg_ch
);

  vta_pkg::cfg_t      cfg;
  vta_pkg::out_item_t result;

  // Input register stage.
  logic              in_valid_r;
  vta_pkg::in_item_t in_item_r;

  // Result register stage.
  logic               out_valid_r;
  vta_pkg::out_item_t out_item_r;

  logic advance;
  logic step;

  // Advance whenever the result register is empty or being drained.
  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  vta_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  vta_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers: input loads on handshake, result on step; both hold otherwise.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r <= in_ch.data;
    end
    if (step) begin
      out_item_r <= result;
    end
  end

endmodule
